>>> sv/pbw_pkg.sv
// ----------------------------------------------------------------------------
// pbw_pkg
// Shared widths, register indexes and lane types for the periodic boundary
// wrap unit.
// ----------------------------------------------------------------------------
package pbw_pkg;

  localparam int unsigned AxesDef      = 3;
  localparam int unsigned CoordBitsDef = 32;
  localparam int unsigned NumLanes     = 3;

  localparam int unsigned TagW   = 16;
  localparam int unsigned KindW  = 2;
  localparam int unsigned PosW   = 31;
  localparam int unsigned WidthW = 30;
  localparam int unsigned OutW   = 32;
  localparam int unsigned DiffW  = 33;
  // Magnitude of a difference fits in 32 bits; one divider step per bit
  localparam int unsigned MagW     = 32;
  localparam int unsigned DivSteps = MagW;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 208;
  localparam int unsigned OutDataW = 112;

  // Request kinds
  localparam logic [KindW-1:0] KIND_DISP  = 2'd0;
  localparam logic [KindW-1:0] KIND_WRAP1 = 2'd1;
  localparam logic [KindW-1:0] KIND_WRAPR = 2'd2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_WIDTH_X = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_WIDTH_Y = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_WIDTH_Z = 2'd2;

  // One stage of lane state
  typedef struct packed {
    logic [WidthW-1:0]       rem;
    logic [MagW-1:0]         num;
    logic                    neg;
    logic                    byp;
    logic signed [DiffW-1:0] byp_val;
    logic [KindW-1:0]        kind;
  } lane_stage_t;

endpackage

>>> sv/pbw_lane.sv
// ----------------------------------------------------------------------------
// pbw_lane
// One axis: operand set-up, pipelined restoring remainder, fold and wrap.
// ----------------------------------------------------------------------------
module pbw_lane import pbw_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [KindW-1:0]         kind_i,
  input  logic signed [PosW-1:0]   a_i,
  input  logic signed [PosW-1:0]   b_i,
  input  logic [WidthW-1:0]        width_i,
  output logic signed [OutW-1:0]   res_o
);

  localparam int unsigned SignBit = (CoordBits > DiffW) ? DiffW - 1 : CoordBits - 1;

  lane_stage_t             stg_q [DivSteps+1];
  lane_stage_t             pre_d;
  logic signed [DiffW-1:0] a_s, b_s, d_s, w_s, src_s;
  logic signed [DiffW-1:0] rs, r2, res_full;
  logic signed [DiffW-1:0] rem_s;

  // Set up operands and the bypass result
  always_comb begin
    a_s   = DiffW'(a_i);
    b_s   = DiffW'(b_i);
    w_s   = signed'({3'b000, width_i});
    d_s   = b_s - a_s;
    src_s = (kind_i == KIND_DISP) ? d_s : a_s;
    pre_d.rem  = '0;
    pre_d.neg  = src_s[DiffW-1];
    pre_d.num  = src_s[DiffW-1] ? MagW'(-src_s) : MagW'(src_s);
    pre_d.kind = kind_i;
    pre_d.byp  = (width_i == '0) || (kind_i != KIND_DISP && kind_i != KIND_WRAPR);
    if (kind_i == KIND_DISP) begin
      pre_d.byp_val = d_s;
    end else if (kind_i == KIND_WRAP1 && width_i != '0) begin
      if (a_s >= w_s) begin
        pre_d.byp_val = a_s - w_s;
      end else if (a_s < 0) begin
        pre_d.byp_val = a_s + w_s;
      end else begin
        pre_d.byp_val = a_s;
      end
    end else begin
      pre_d.byp_val = a_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q[0] <= pre_d;
    end
  end

  // Remainder steps: shift one dividend bit in, subtract the width if it fits
  for (genvar k = 1; k <= DivSteps; k++) begin : g_div
    logic [WidthW:0] trial;
    lane_stage_t     nxt;
    always_comb begin
      nxt   = stg_q[k-1];
      trial = {stg_q[k-1].rem, stg_q[k-1].num[MagW-1]};
      if (trial >= {1'b0, width_i}) begin
        trial = trial - {1'b0, width_i};
      end
      nxt.rem = trial[WidthW-1:0];
      nxt.num = {stg_q[k-1].num[MagW-2:0], 1'b0};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[k] <= nxt;
      end
    end
  end

  // Fold or wrap the remainder (or take the bypass value), then fit to the coordinate width
  always_comb begin
    rem_s = signed'({3'b000, stg_q[DivSteps].rem});
    rs    = stg_q[DivSteps].neg ? -rem_s : rem_s;
    r2    = rs <<< 1;
    if (stg_q[DivSteps].byp) begin
      res_full = stg_q[DivSteps].byp_val;
    end else if (stg_q[DivSteps].kind == KIND_DISP) begin
      if (r2 > w_s) begin
        res_full = rs - w_s;
      end else if (r2 < -w_s) begin
        res_full = rs + w_s;
      end else begin
        res_full = rs;
      end
    end else if (stg_q[DivSteps].neg && rem_s != 0) begin
      res_full = w_s - rem_s;
    end else begin
      res_full = rem_s;
    end
    for (int i = 0; i < OutW; i++) begin
      res_o[i] = (i <= SignBit) ? res_full[i] : res_full[SignBit];
    end
  end

endmodule

>>> sv/periodic_boundary_wrap_unit.sv
// ----------------------------------------------------------------------------
// periodic_boundary_wrap_unit
// Minimum-image displacement and periodic wrapping, three axis lanes.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_axis: tuser carries the request kind, tdata the
//   node tag and points a and b. Each beat yields one output beat on m_axis
//   with the echoed tag and one Q15.16 coordinate per axis.
//   Widths are written on the cfg channel (index 0..2), which is always
//   ready; write them only while no beat is in flight.
//   The pipeline is one set-up stage, 32 restoring remainder stages (one
//   quotient bit each) and the output register. Throughput is one beat per
//   cycle while m_axis does not stall.
//   The three lanes run in lock step and the output register merges them.
//   When m_axis stalls the whole pipeline holds and s_axis_tready drops
//   until the output beat is taken.
//   Reset clears all valid flags and the width registers to zero, so every
//   axis starts out non-periodic.
// ----------------------------------------------------------------------------
module periodic_boundary_wrap_unit import pbw_pkg::*; #(
  parameter int unsigned Axes      = AxesDef,
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // node_tag[15:0], a_x, a_y, a_z, b_x, b_y, b_z (31 bits each), zero pad
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // kind[1:0]
  input  logic [KindW-1:0]    s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // tag_out[15:0], out_x[47:16], out_y[79:48], out_z[111:80]
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [WidthW-1:0]   cfg_data_i
);

  localparam int unsigned Depth = DivSteps + 1;

  logic                    en;
  logic [WidthW-1:0]       width_q [NumLanes];
  logic [Depth-1:0]        vld_q;
  logic [TagW-1:0]         tag_q [Depth];
  logic signed [OutW-1:0]  lane_res [NumLanes];
  logic                    out_vld_q;
  logic [OutDataW-1:0]     out_q;

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

  // Width registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLanes; i++) width_q[i] <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WIDTH_X: width_q[0] <= cfg_data_i;
        REG_WIDTH_Y: width_q[1] <= cfg_data_i;
        REG_WIDTH_Z: width_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Axis lanes
  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    logic [WidthW-1:0] lane_w;
    assign lane_w = (l < Axes) ? width_q[l] : '0;
    pbw_lane #(.CoordBits(CoordBits)) u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .kind_i  (s_axis_tuser_i),
      .a_i     (s_axis_tdata_i[TagW + l*PosW +: PosW]),
      .b_i     (s_axis_tdata_i[TagW + (l+3)*PosW +: PosW]),
      .width_i (lane_w),
      .res_o   (lane_res[l])
    );
  end

  // Advance valid flags alongside the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[Depth-2:0], s_axis_tvalid_i};
      out_vld_q <= vld_q[Depth-1];
    end
  end

  // Carry the tag and merge lane results into the output beat
  always_ff @(posedge clk_i) begin
    if (en) begin
      tag_q[0] <= s_axis_tdata_i[TagW-1:0];
      for (int i = 1; i < Depth; i++) tag_q[i] <= tag_q[i-1];
      out_q <= {lane_res[2], lane_res[1], lane_res[0], tag_q[Depth-1]};
    end
  end

endmodule
